>>> src/hidkb_pkg.sv
`timescale 1ns / 1ps

package hidkb_pkg;

   localparam int KEY_SLOTS   = 6;
   localparam int SLOT_DEPTH  = 6;

   localparam logic [7:0] SHIFT_MASK = 8'h22;
   localparam logic [7:0] FIRST_CODE = 8'd4;
   localparam logic [7:0] CODE_LIMIT = 8'd75;

   typedef struct packed {
      logic [7:0] modifiers;
      logic [7:0] key_slot0;
      logic [7:0] key_slot1;
      logic [7:0] key_slot2;
      logic [7:0] key_slot3;
      logic [7:0] key_slot4;
      logic [7:0] key_slot5;
   } req_type;

   typedef struct packed {
      logic       char_valid;
      logic [6:0] char_code;
   } rsp_type;

   // what one lane reports to the merge stage
   typedef struct packed {
      logic       hit;
      logic [7:0] code;
   } lane_type;

   // usage code to ascii, indexed by the usage code itself
   function automatic logic [6:0] key_char(input logic [7:0] code, input logic shift);
      logic [6:0] ch;
      ch = 7'h00;
      if (code >= FIRST_CODE && code < CODE_LIMIT) begin
         if (code <= 8'd29) begin
            // letters
            ch = (shift ? 7'h41 : 7'h61) + 7'(code - FIRST_CODE);
         end else begin
            case (code)
               8'd30:   ch = shift ? 7'h21 : 7'h31;
               8'd31:   ch = shift ? 7'h40 : 7'h32;
               8'd32:   ch = shift ? 7'h23 : 7'h33;
               8'd33:   ch = shift ? 7'h24 : 7'h34;
               8'd34:   ch = shift ? 7'h25 : 7'h35;
               8'd35:   ch = shift ? 7'h5e : 7'h36;
               8'd36:   ch = shift ? 7'h26 : 7'h37;
               8'd37:   ch = shift ? 7'h2a : 7'h38;
               8'd38:   ch = shift ? 7'h28 : 7'h39;
               8'd39:   ch = shift ? 7'h29 : 7'h30;
               8'd40:   ch = 7'h0a;
               8'd41:   ch = 7'h1b;
               8'd42:   ch = 7'h08;
               8'd43:   ch = 7'h09;
               8'd44:   ch = 7'h20;
               8'd45:   ch = shift ? 7'h5f : 7'h2d;
               8'd46:   ch = shift ? 7'h2b : 7'h3d;
               8'd47:   ch = shift ? 7'h7b : 7'h5b;
               8'd48:   ch = shift ? 7'h7d : 7'h5d;
               8'd49:   ch = shift ? 7'h7c : 7'h5c;
               8'd51:   ch = shift ? 7'h3a : 7'h3b;
               8'd52:   ch = shift ? 7'h22 : 7'h27;
               8'd53:   ch = shift ? 7'h7e : 7'h60;
               8'd54:   ch = shift ? 7'h3c : 7'h2c;
               8'd55:   ch = shift ? 7'h3e : 7'h2e;
               8'd56:   ch = shift ? 7'h3f : 7'h2f;
               default: ch = 7'h00;
            endcase
         end
      end
      return ch;
   endfunction

endpackage

>>> src/hidkb_lane.sv
`timescale 1ns / 1ps

module hidkb_lane (
   input  logic [7:0]          code,
   input  logic [7:0]          prev_code,
   output hidkb_pkg::lane_type lane
);

   // newly pressed: something in the slot and not what was there last report
   assign lane.hit  = (code != 8'd0) && (code != prev_code);
   assign lane.code = code;

endmodule

>>> src/hidkb_merge.sv
`timescale 1ns / 1ps

module hidkb_merge (
   input  hidkb_pkg::lane_type lanes [hidkb_pkg::KEY_SLOTS],
   input  logic [7:0]          modifiers,
   output hidkb_pkg::rsp_type  rsp
);

   logic       found;
   logic [7:0] pick_code;
   logic       shift;
   logic [6:0] ch;

   // lowest slot with a hit wins
   always_comb begin
      found     = 1'b0;
      pick_code = 8'd0;
      for (int n = 0; n < hidkb_pkg::KEY_SLOTS; n++) begin
         if (!found && lanes[n].hit) begin
            found     = 1'b1;
            pick_code = lanes[n].code;
         end
      end
   end

   assign shift = |(modifiers & hidkb_pkg::SHIFT_MASK);
   assign ch    = found ? hidkb_pkg::key_char(pick_code, shift) : 7'h00;

   assign rsp.char_valid = (ch != 7'h00);
   assign rsp.char_code  = ch;

endmodule

>>> src/hid_keyboard_report_to_ascii.sv
`timescale 1ns / 1ps

// channel   ports                              payload
// req       req_valid, req_stall, req_data     hidkb_pkg::req_type (modifiers, six slots)
// rsp       rsp_valid, rsp_stall, rsp_data     hidkb_pkg::rsp_type (char_valid, char_code)
//
// one report per cycle while req_stall is low: six slot lanes compare against
// the stored report, the merge stage picks the first new key and looks it up,
// and the result is registered in the output register, or in the skid register.
// a skid register holds one result while rsp is stalled, so req_stall rises
// only when both the output and skid registers are full.
// synchronous reset clears the stored slots to zero and empties both registers.

module hid_keyboard_report_to_ascii (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  hidkb_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output hidkb_pkg::rsp_type rsp_data
);

   logic [7:0]          slots_all [hidkb_pkg::SLOT_DEPTH];
   logic [7:0]          prev_ff   [hidkb_pkg::KEY_SLOTS];
   hidkb_pkg::lane_type lanes     [hidkb_pkg::KEY_SLOTS];
   hidkb_pkg::rsp_type  result;

   hidkb_pkg::rsp_type  out_ff;
   logic                out_valid_ff;
   hidkb_pkg::rsp_type  skid_ff;
   logic                skid_valid_ff;

   logic                accept;
   logic                out_free;

   assign slots_all[0] = req_data.key_slot0;
   assign slots_all[1] = req_data.key_slot1;
   assign slots_all[2] = req_data.key_slot2;
   assign slots_all[3] = req_data.key_slot3;
   assign slots_all[4] = req_data.key_slot4;
   assign slots_all[5] = req_data.key_slot5;

   for (genvar g = 0; g < hidkb_pkg::KEY_SLOTS; g++) begin : g_lane
      hidkb_lane u_lane (
         .code      (slots_all[g]),
         .prev_code (prev_ff[g]),
         .lane      (lanes[g])
      );
   end

   hidkb_merge u_merge (
      .lanes     (lanes),
      .modifiers (req_data.modifiers),
      .rsp       (result)
   );

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < hidkb_pkg::KEY_SLOTS; n++) begin
            prev_ff[n] <= 8'd0;
         end
      end else if (accept) begin
         for (int n = 0; n < hidkb_pkg::KEY_SLOTS; n++) begin
            prev_ff[n] <= slots_all[n];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end
      if (!out_free && accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> src/hidkb_checker.sv
`timescale 1ns / 1ps

module hidkb_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input hidkb_pkg::rsp_type rsp_data
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // char_valid is set exactly when a character code is present
   a_char_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.char_valid == (rsp_data.char_code != 7'h00)))
      else $error("char_valid disagrees with char_code");

   // input backpressure only when a result already waits at the output
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall with empty output");

   // nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

   // an accepted transaction with the output free shows up next cycle
   a_fwd: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (!rsp_valid || !rsp_stall) |=> rsp_valid)
      else $error("accepted transaction did not reach output");

endmodule

bind hid_keyboard_report_to_ascii hidkb_checker u_hidkb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> dv/hid_keyboard_report_to_ascii_checker.sv
`timescale 1ns / 1ps

module hid_keyboard_report_to_ascii_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  hidkb_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  hidkb_pkg::rsp_type rsp_data,
   output int unsigned        pending_chars,
   output int unsigned        fail_count,
   output int unsigned        results_checked,
   output int unsigned        chars_checked
);

   import hidkb_pkg::*;

   localparam logic [7:0] USAGE_LAST_DIGIT  = 8'd39;
   localparam logic [7:0] USAGE_ENTER       = 8'd40;
   localparam logic [7:0] USAGE_ESCAPE      = 8'd41;
   localparam logic [7:0] USAGE_BACKSPACE   = 8'd42;
   localparam logic [7:0] USAGE_TAB         = 8'd43;
   localparam logic [7:0] USAGE_SPACE       = 8'd44;
   localparam logic [7:0] USAGE_MINUS       = 8'd45;
   localparam logic [7:0] USAGE_NON_US_HASH = 8'd50;
   localparam logic [7:0] USAGE_SLASH       = 8'd56;

   logic [7:0] last_slots [SLOT_DEPTH];
   rsp_type    expected_chars [$];

   function automatic logic [6:0] usage_to_ascii(input logic [7:0] code, input logic shifted);
      string      alnum;
      string      punct;
      logic [6:0] ch;
      // letters then digits, codes 4 to 39
      if (shifted) begin
         alnum = "ABCDEFGHIJKLMNOPQRSTUVWXYZ!@#$%^&*()";
         punct = "_+{}| :\"~<>?";
      end else begin
         alnum = "abcdefghijklmnopqrstuvwxyz1234567890";
         punct = "-=[]\\ ;'`,./";
      end
      ch = 7'h00;
      if (code >= FIRST_CODE && code <= USAGE_LAST_DIGIT) begin
         ch = 7'(alnum[code - FIRST_CODE]);
      end else begin
         case (code)
            USAGE_ENTER:     ch = 7'h0a;
            USAGE_ESCAPE:    ch = 7'h1b;
            USAGE_BACKSPACE: ch = 7'h08;
            USAGE_TAB:       ch = 7'h09;
            USAGE_SPACE:     ch = 7'h20;
            default: begin
               if (code >= USAGE_MINUS && code <= USAGE_SLASH && code != USAGE_NON_US_HASH)
                  ch = 7'(punct[code - USAGE_MINUS]);
            end
         endcase
      end
      return ch;
   endfunction

   // first slot that is nonzero and differs from last report picks the character
   function automatic rsp_type decode_report(input req_type r);
      logic [7:0] slots [SLOT_DEPTH];
      logic [6:0] ch;
      logic       found;
      rsp_type    res;
      slots = '{r.key_slot0, r.key_slot1, r.key_slot2, r.key_slot3, r.key_slot4, r.key_slot5};
      ch    = 7'h00;
      found = 1'b0;
      for (int n = 0; n < KEY_SLOTS && n < SLOT_DEPTH; n++) begin
         if (!found && slots[n] != 8'h00 && slots[n] != last_slots[n]) begin
            found = 1'b1;
            ch    = usage_to_ascii(slots[n], (r.modifiers & SHIFT_MASK) != 8'h00);
         end
      end
      for (int n = 0; n < KEY_SLOTS && n < SLOT_DEPTH; n++)
         last_slots[n] = slots[n];
      res.char_valid = (ch != 7'h00);
      res.char_code  = ch;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
               results_checked, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_chars.delete();
         for (int n = 0; n < SLOT_DEPTH; n++)
            last_slots[n] = 8'h00;
         fail_count      = 0;
         results_checked = 0;
         chars_checked   = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("result with no report pending", rsp_data, 0);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.char_valid !== want.char_valid)
                  report_mismatch("char_valid", rsp_data.char_valid, want.char_valid);
               if (rsp_data.char_code !== want.char_code)
                  report_mismatch("char_code", rsp_data.char_code, want.char_code);
               if (want.char_valid)
                  chars_checked++;
            end
            results_checked++;
         end
         // the request transaction of this edge cannot be answered before the next one
         if (req_valid && !req_stall)
            expected_chars.push_back(decode_report(req_data));
      end
      pending_chars <= expected_chars.size();
   end

endmodule

>>> dv/hid_keyboard_report_to_ascii_tb.sv
`timescale 1ns / 1ps

module hid_keyboard_report_to_ascii_tb;

   import hidkb_pkg::*;

   localparam int         RANDOM_REPORTS = 1900;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         DRAIN_CYCLES   = 4;
   localparam logic [7:0] PRINTABLE_LAST = 8'd56;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int unsigned pending_chars;
   int unsigned fail_count;
   int unsigned results_checked;
   int unsigned chars_checked;
   int unsigned reports_sent = 0;
   int unsigned idle_cycles  = 0;
   bit          hold_request = 1'b0;
   bit          quiet        = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   hid_keyboard_report_to_ascii i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   hid_keyboard_report_to_ascii_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .pending_chars   (pending_chars),
      .fail_count      (fail_count),
      .results_checked (results_checked),
      .chars_checked   (chars_checked)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // typing-like evolution of the previous report, with some pure noise
   function automatic req_type next_report(input req_type prev);
      req_type     r;
      logic [63:0] raw;
      logic [7:0]  slots [6];
      logic [7:0]  packed_slots [6];
      int          pick;
      int          k;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         raw = {$urandom, $urandom};
         r   = raw[55:0];
         return r;
      end
      r     = prev;
      slots = '{prev.key_slot0, prev.key_slot1, prev.key_slot2,
                prev.key_slot3, prev.key_slot4, prev.key_slot5};
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         r.modifiers = (prev.modifiers & ~SHIFT_MASK) | (8'($urandom) & SHIFT_MASK);
      end else if (pick < 30) begin
         r.modifiers = 8'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         // key press into the first empty slot, or over a random one when full
         k = $urandom_range(0, 5);
         for (int n = 5; n >= 0; n--)
            if (slots[n] == 8'h00) k = n;
         if ($urandom_range(0, 99) < 85) slots[k] = 8'($urandom_range(FIRST_CODE, PRINTABLE_LAST));
         else slots[k] = 8'($urandom_range(1, 255));
      end else if (pick < 70) begin
         slots[$urandom_range(0, 5)] = 8'h00;
         if ($urandom_range(0, 1) == 1) begin
            // release with the remaining keys moved up, as real keyboards do
            k = 0;
            for (int n = 0; n < 6; n++)
               packed_slots[n] = 8'h00;
            for (int n = 0; n < 6; n++) begin
               if (slots[n] != 8'h00) begin
                  packed_slots[k] = slots[n];
                  k++;
               end
            end
            slots = packed_slots;
         end
      end else if (pick < 85) begin
         for (int n = 0; n < 6; n++)
            slots[n] = 8'h00;
      end
      r.key_slot0 = slots[0];
      r.key_slot1 = slots[1];
      r.key_slot2 = slots[2];
      r.key_slot3 = slots[3];
      r.key_slot4 = slots[4];
      r.key_slot5 = slots[5];
      return r;
   endfunction

   task automatic send_report(input req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      reports_sent++;
   endtask

   // receiver: random stall stretches, and a long hold-off when asked
   initial begin
      int n;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", idle_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_type prev;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_report(req_type'{8'h00, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
      send_report(req_type'{8'h00, 8'd4,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});  // a
      send_report(req_type'{8'h00, 8'd4,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});  // held
      send_report(req_type'{8'h02, 8'd4,   8'd29,  8'd0,   8'd0,   8'd0,   8'd0});  // Z
      send_report(req_type'{8'h20, 8'd0,   8'd0,   8'd30,  8'd0,   8'd0,   8'd0});  // !
      send_report(req_type'{8'hdd, 8'd56,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0});  // /
      send_report(req_type'{8'hff, 8'd56,  8'd56,  8'd0,   8'd0,   8'd0,   8'd0});  // ?
      // first changed slot has no character, later new key is ignored
      send_report(req_type'{8'h00, 8'd50,  8'd4,   8'd0,   8'd0,   8'd0,   8'd0});
      send_report(req_type'{8'h00, 8'd3,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
      send_report(req_type'{8'h00, 8'd75,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
      send_report(req_type'{8'h00, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
      send_report(req_type'{8'h00, 8'd74,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
      send_report(req_type'{8'h00, 8'd57,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
      send_report(req_type'{8'h00, 8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
      send_report(req_type'{8'h02, 8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd0});
      send_report(req_type'{8'h00, 8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd39});
      send_report(req_type'{8'h00, 8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd0});
      send_report(req_type'{8'h00, 8'd0,   8'd41,  8'd42,  8'd43,  8'd44,  8'd0});
      send_report(req_type'{8'h00, 8'd45,  8'd46,  8'd47,  8'd48,  8'd49,  8'd51});
      send_report(req_type'{8'h22, 8'd52,  8'd53,  8'd54,  8'd55,  8'd56,  8'd45});
      send_report(req_type'{8'hff, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
      send_report(req_type'{8'h00, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0});
      send_report(req_type'{8'h20, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd29});
      send_report(req_type'{8'h00, 8'd53,  8'd0,   8'd0,   8'd0,   8'd0,   8'd29});
      prev = req_type'{8'h02, 8'd49, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
      send_report(prev);

      for (int i = 0; i < RANDOM_REPORTS; i++) begin
         if (i == 600 || i == 1400)
            hold_request = 1'b1;
         quiet = (i >= 1000 && i < 1150);
         prev  = next_report(prev);
         send_report(prev);
      end
      req_valid <= 1'b0;
      quiet = 1'b0;

      do @(posedge clock); while (pending_chars != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d keyboard reports, checked %0d results, %0d of them characters",
               reports_sent, results_checked, chars_checked);
      $display("random gaps on both sides, two %0d-cycle receiver hold-offs, %0d mismatches",
               HOLD_CYCLES, fail_count);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> hid_keyboard_report_to_ascii.f
src/hidkb_pkg.sv
src/hidkb_lane.sv
src/hidkb_merge.sv
src/hid_keyboard_report_to_ascii.sv
src/hidkb_checker.sv
dv/hid_keyboard_report_to_ascii_checker.sv
dv/hid_keyboard_report_to_ascii_tb.sv
